// ===== rtl/core/sha1_pkg.sv =====
package sha1_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hefcdab89;
   localparam logic [31:0] H2 = 32'h98badcfe;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hc3d2e1f0;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      begin
         if (r < 7'd20) k = 32'h5a827999;
         else if (r < 7'd40) k = 32'h6ed9eba1;
         else if (r < 7'd60) k = 32'h8f1bbcdc;
         else k = 32'hca62c1d6;
         return k;
      end
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      begin
         if (r < 7'd20) f = (b & c) | (~b & d);
         else if (r >= 7'd40 && r < 7'd60) f = (b & c) | (b & d) | (c & d);
         else f = b ^ c ^ d;
         return f;
      end
   endfunction

endpackage

// ===== rtl/core/sha1_fifo.sv =====
module sha1_fifo import sha1_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    pop,
   output req_type pop_data,
   output logic    empty
);
   req_type    mem_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full = cnt_ff == 3'd4;
   assign empty = cnt_ff == 3'd0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = do_push ? wr_ff + 2'd1 : wr_ff;
      rd_in = do_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, do_push} - {2'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end
endmodule

// ===== rtl/core/sha1_core.sv =====
module sha1_core import sha1_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_take,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_take
);
   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_LEN, S_ROUND, S_ADD, S_OUT
   } state_type;

   state_type   state_ff;
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]  round_ff;
   logic [5:0]  idx_ff;
   logic [63:0] bits_ff;
   logic        final_ff, extra_ff;
   logic [2:0]  out_ff;
   logic [31:0] w_cur, w_new, t_val;
   logic        w_len_done_ff;

   // Bytes are shifted into the low end of the word window; after 64 bytes
   // word 0 holds the first four bytes.
   assign w_cur = w_ff[0];
   assign w_new = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} << 1 |
                  {31'b0, w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31]};
   assign t_val = {a_ff[26:0], a_ff[31:27]} + round_f(round_ff, b_ff, c_ff, d_ff) +
                  e_ff + round_k(round_ff) + w_cur;

   assign req_take = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_OUT;
   assign rsp_data = '{digest_word: h_ff[out_ff], word_index: out_ff,
                       last_word: out_ff == 3'd4};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         h_ff <= '{H0, H1, H2, H3, H4};
         idx_ff <= '0;
         bits_ff <= '0;
         final_ff <= 1'b0;
         extra_ff <= 1'b0;
         out_ff <= '0;
         round_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  final_ff <= req_data.end_of_message;
                  if (req_data.has_byte) begin
                     w_ff[idx_ff[5:2]] <= {w_ff[idx_ff[5:2]][23:0], req_data.data_byte};
                     bits_ff <= bits_ff + 64'd8;
                     idx_ff <= idx_ff + 6'd1;
                     if (idx_ff == 6'd63) begin
                        state_ff <= S_ROUND;
                        round_ff <= '0;
                        {a_ff, b_ff, c_ff, d_ff, e_ff} <= {h_ff[0], h_ff[1], h_ff[2],
                                                           h_ff[3], h_ff[4]};
                     end else if (req_data.end_of_message) state_ff <= S_PAD;
                  end else if (req_data.end_of_message) state_ff <= S_PAD;
               end
            end
            S_PAD: begin
               // 0x80 then zeros, one byte a cycle, to byte 56 or the block end.
               w_ff[idx_ff[5:2]] <= {w_ff[idx_ff[5:2]][23:0],
                                     extra_ff ? 8'h00 : PAD_BYTE};
               extra_ff <= 1'b1;
               idx_ff <= idx_ff + 6'd1;
               if (idx_ff == 6'd55) state_ff <= S_LEN;
               else if (idx_ff == 6'd63) begin
                  state_ff <= S_ROUND;
                  round_ff <= '0;
                  {a_ff, b_ff, c_ff, d_ff, e_ff} <= {h_ff[0], h_ff[1], h_ff[2],
                                                     h_ff[3], h_ff[4]};
               end
            end
            S_LEN: begin
               w_ff[14] <= bits_ff[63:32];
               w_ff[15] <= bits_ff[31:0];
               idx_ff <= '0;
               extra_ff <= 1'b0;
               final_ff <= 1'b0;
               out_ff <= '0;
               state_ff <= S_ROUND;
               round_ff <= '0;
               {a_ff, b_ff, c_ff, d_ff, e_ff} <= {h_ff[0], h_ff[1], h_ff[2],
                                                  h_ff[3], h_ff[4]};
            end
            S_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
               w_ff[15] <= w_new;
               e_ff <= d_ff;
               d_ff <= c_ff;
               c_ff <= {b_ff[1:0], b_ff[31:2]};
               b_ff <= a_ff;
               a_ff <= t_val;
               round_ff <= round_ff + 7'd1;
               if (round_ff == 7'd79) state_ff <= S_ADD;
            end
            S_ADD: begin
               h_ff[0] <= h_ff[0] + a_ff;
               h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff;
               h_ff[3] <= h_ff[3] + d_ff;
               h_ff[4] <= h_ff[4] + e_ff;
               // The block that carried the length field ends the message.
               if (final_ff) state_ff <= S_PAD;
               else if (w_len_done_ff) state_ff <= S_OUT;
               else state_ff <= S_IDLE;
            end
            S_OUT: begin
               if (rsp_take) begin
                  out_ff <= out_ff + 3'd1;
                  if (out_ff == 3'd4) begin
                     state_ff <= S_IDLE;
                     h_ff <= '{H0, H1, H2, H3, H4};
                     bits_ff <= '0;
                     out_ff <= '0;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Marks that the block in flight carries the length field.
   always_ff @(posedge clock) begin
      if (reset) w_len_done_ff <= 1'b0;
      else if (state_ff == S_LEN) w_len_done_ff <= 1'b1;
      else if (state_ff == S_ADD) w_len_done_ff <= 1'b0;
   end
endmodule

// ===== rtl/core/sha1_stream_hasher.sv =====
// Channel  | Ports                              | Moves
// request  | req_push, req_full, req_payload    | one byte and flags
// response | rsp_pop, rsp_empty, rsp_payload    | one digest word
// Bytes are taken only while the core is idle; every full block then runs
// its rounds through the single round unit, and no request is taken meanwhile.
// Ending a message pads one byte a cycle and runs one or two blocks.
// Reset is synchronous and restores the initial hash values.
// A four-entry queue lets requests arrive while the rounds run.
module sha1_stream_hasher import sha1_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_payload,
   output logic    req_full,
   input  logic    rsp_pop,
   output rsp_type rsp_payload,
   output logic    rsp_empty
);
   req_type q_data;
   logic    q_empty, q_take, out_valid;

   sha1_fifo u_fifo (
      .clock(clock), .reset(reset), .push(req_push), .push_data(req_payload),
      .full(req_full), .pop(q_take), .pop_data(q_data), .empty(q_empty)
   );

   sha1_core u_core (
      .clock(clock), .reset(reset), .req_valid(!q_empty), .req_data(q_data),
      .req_take(q_take), .rsp_valid(out_valid), .rsp_data(rsp_payload),
      .rsp_take(rsp_pop)
   );

   assign rsp_empty = !out_valid;
endmodule

// ===== rtl/core/sha1_checker.sv =====
module sha1_checker import sha1_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_pop,
   input logic    rsp_empty,
   input rsp_type rsp_payload
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_payload.last_word == (rsp_payload.word_index == 3'd4)))
      else $error("last flag mismatch");
   a_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_payload.word_index <= 3'd4)
      else $error("word index out of range");
   a_next: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_payload.last_word) |=>
      (!rsp_empty && rsp_payload.word_index == $past(rsp_payload.word_index) + 3'd1))
      else $error("digest words not consecutive");
endmodule

bind sha1_stream_hasher sha1_checker u_checker (
   .clock(clock), .reset(reset), .rsp_pop(rsp_pop), .rsp_empty(rsp_empty),
   .rsp_payload(rsp_payload)
);

// ===== dv/tb_top.sv =====
module tb_top;
   import sha1_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_payload = '0;
   logic    req_full;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_payload;
   logic    rsp_empty;

   sha1_stream_hasher dut (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_payload(req_payload),
      .req_full   (req_full),
      .rsp_pop    (rsp_pop),
      .rsp_payload(rsp_payload),
      .rsp_empty  (rsp_empty)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Requests waiting to be offered, and digest words still owed by the block.
   req_type pending_reqs[$];
   rsp_type digest_q[$];
   int      error_count = 0;
   int      words_seen = 0;
   int      item_total = 0;

   // Private copy of the hashing state: chaining words, block buffer,
   // byte position within the block and the running message length in bits.
   logic [31:0] hash_h[5];
   logic [7:0]  blk[64];
   int          blk_pos;
   logic [63:0] msg_bits;

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // One FIPS 180 compression of blk into hash_h.
   function automatic void compress_blk();
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5a827999;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ed9eba1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8f1bbcdc;
         end else begin
            f = b ^ c ^ d;
            k = 32'hca62c1d6;
         end
         t = rol(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rol(b, 30);
         b = a;
         a = t;
      end
      hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
   endfunction

   function automatic void restart_hash();
      hash_h[0] = H0; hash_h[1] = H1; hash_h[2] = H2; hash_h[3] = H3; hash_h[4] = H4;
      blk_pos = 0;
      msg_bits = '0;
   endfunction

   // Apply one accepted request to the private state. A request that ends a
   // message pads the tail, spills into an extra block when the length field
   // no longer fits, and queues the five digest words.
   function automatic void absorb_request(input req_type r);
      rsp_type w;
      if (r.has_byte) begin
         blk[blk_pos] = r.data_byte;
         msg_bits += 64'd8;
         blk_pos++;
         if (blk_pos == 64) begin
            compress_blk();
            blk_pos = 0;
         end
      end
      if (!r.end_of_message) return;
      blk[blk_pos] = PAD_BYTE;
      for (int i = blk_pos + 1; i < 64; i++) blk[i] = 8'h00;
      if (blk_pos >= 56) begin
         compress_blk();
         for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk[63-i] = msg_bits[8*i +: 8];
      compress_blk();
      for (int i = 0; i < 5; i++) begin
         w.digest_word = hash_h[i];
         w.word_index  = 3'(i);
         w.last_word   = (i == 4);
         digest_q.push_back(w);
      end
      restart_hash();
   endfunction

   // Queue one message of len bytes. When merge_end is set the last byte
   // carries the end flag; otherwise a separate request with no byte ends it.
   // Now and then an empty request is slipped in; the block must ignore it.
   task automatic queue_message(input int len, input bit merge_end, input bit noise);
      req_type r;
      for (int i = 0; i < len; i++) begin
         if (noise && $urandom_range(0, 9) == 0) begin
            r.data_byte      = 8'($urandom);
            r.has_byte       = 1'b0;
            r.end_of_message = 1'b0;
            pending_reqs.push_back(r);
            item_total++;
         end
         r.data_byte      = 8'($urandom);
         r.has_byte       = 1'b1;
         r.end_of_message = merge_end && (i == len - 1);
         pending_reqs.push_back(r);
         item_total++;
      end
      if (!merge_end || len == 0) begin
         r.data_byte      = 8'($urandom);
         r.has_byte       = 1'b0;
         r.end_of_message = 1'b1;
         pending_reqs.push_back(r);
         item_total++;
      end
   endtask

   // Driver: offers the head of pending_reqs in bursts separated by gaps.
   // The next request is chosen once per edge so push sees one assignment.
   int burst_left = 4;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            absorb_request(req_payload);
            void'(pending_reqs.pop_front());
         end
         if (!req_push || !req_full) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_push    <= 1'b1;
               req_payload <= pending_reqs[0];
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every popped digest word against the oldest expectation.
   // The receiver alternates between stretches of full speed and random
   // stalls, and once holds off for a long stretch so the block backs up.
   int  cycle_count = 0;
   int  hold_left = 0;
   bit  held_once = 1'b0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         cycle_count++;
         if (rsp_pop && !rsp_empty) begin
            words_seen++;
            if (digest_q.size() == 0) begin
               $error("unexpected digest word %h", rsp_payload.digest_word);
               error_count++;
            end else begin
               want = digest_q.pop_front();
               if (rsp_payload.digest_word !== want.digest_word) begin
                  $error("digest_word expected %h actual %h",
                         want.digest_word, rsp_payload.digest_word);
                  error_count++;
               end
               if (rsp_payload.word_index !== want.word_index) begin
                  $error("word_index expected %0d actual %0d",
                         want.word_index, rsp_payload.word_index);
                  error_count++;
               end
               if (rsp_payload.last_word !== want.last_word) begin
                  $error("last_word expected %0d actual %0d",
                         want.last_word, rsp_payload.last_word);
                  error_count++;
               end
            end
         end
         if (!held_once && words_seen >= 20) begin
            held_once = 1'b1;
            hold_left = 700;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (cycle_count[9]) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Wait until the driver has nothing left and every digest word is in.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_push || digest_q.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int len;
      restart_hash();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: the empty message, an empty request on its own, a single
      // byte of all ones ending with the byte, and a zero byte ended apart.
      queue_message(0, 1'b0, 1'b0);
      pending_reqs.push_back('{data_byte: 8'hff, has_byte: 1'b0, end_of_message: 1'b0});
      pending_reqs.push_back('{data_byte: 8'hff, has_byte: 1'b1, end_of_message: 1'b1});
      pending_reqs.push_back('{data_byte: 8'h00, has_byte: 1'b1, end_of_message: 1'b0});
      pending_reqs.push_back('{data_byte: 8'h00, has_byte: 1'b0, end_of_message: 1'b1});
      // The classic three-byte message.
      pending_reqs.push_back('{data_byte: 8'h61, has_byte: 1'b1, end_of_message: 1'b0});
      pending_reqs.push_back('{data_byte: 8'h62, has_byte: 1'b1, end_of_message: 1'b0});
      pending_reqs.push_back('{data_byte: 8'h63, has_byte: 1'b1, end_of_message: 1'b1});
      item_total += 7;

      // Sender pause: nothing more is offered until the digests are back.
      drain();

      // Random messages. Lengths cluster around the padding boundaries
      // (55, 56, 63, 64 bytes) so late padding and full-block ends recur.
      while (item_total < 430) begin
         case ($urandom_range(0, 5))
            0: len = $urandom_range(0, 8);
            1: len = $urandom_range(53, 66);
            2: len = $urandom_range(118, 130);
            default: len = $urandom_range(0, 70);
         endcase
         queue_message(len, $urandom_range(0, 1), 1'b1);
         if ($urandom_range(0, 15) == 0) drain();
      end

      drain();
      repeat (300) @(posedge clock);
      if (error_count == 0 && digest_q.size() == 0) begin
         $display("PASS sha1_stream_hasher");
      end else begin
         $display("FAIL sha1_stream_hasher");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL sha1_stream_hasher");
      $finish;
   end

endmodule
